// ===== design/tmwf_pkg.sv =====
package tmwf_pkg;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/tmwf_ram.sv =====
module tmwf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tmwf_divider.sv =====
module tmwf_divider #(
  parameter int DIVIDEND_W = 15,
  parameter int DIVISOR_W  = 3,
  parameter int QUOT_W     = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0]     divisor,
  output logic [QUOT_W-1:0]        quotient,
  output tmwf_pkg::div_status_t    status
);
  import tmwf_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [STEP_W-1:0]     steps;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    rem_shift;
  logic                  fits;

  // Restoring division, one quotient bit per cycle, dividend shifted in MSB first.
  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    fits      = rem_shift >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      if (start) begin
        done  <= 1'b0;
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
        quo   <= dividend;
        rem   <= '0;
        dsr   <= divisor;
      end else if (busy) begin
        quo <= {quo[DIVIDEND_W-2:0], fits};
        if (fits) begin
          rem <= DIVISOR_W'(rem_shift - {1'b0, dsr});
        end else begin
          rem <= rem_shift[DIVISOR_W-1:0];
        end
        steps <= steps - STEP_W'(1);
        done  <= (steps == STEP_W'(1));
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // The mean never exceeds the largest sample, so the upper bits are zero.
  assign quotient    = quo[QUOT_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== design/trimmed_mean_window_filter.sv =====
// Trimmed-mean window filter. Each accepted word stores one sample into a
// ring window of WINDOW_LEN entries and the block returns the truncated mean
// of the nonzero values at sorted ranks RANK_FIRST to RANK_END-1, or the
// sample itself when there is none. The window sits in a ring memory and a
// second memory keeps the same values in ascending order; each word removes
// the overwritten value and inserts the new one in a single pass through the
// sorted memory, one entry per cycle, while the middle ranks are summed. A
// bit-serial divider then forms the mean. A word that needs the divider
// goes from acceptance to a valid result by these steps: reading the
// overwritten value, the sorted-memory pass, starting the divider, the
// division and loading the output register. The sum that is divided is
// SAMPLE_BITS plus the bits of the count wide, 15 bits at the default sizes.
// When no middle-rank value is nonzero the divider is skipped. A new word is
// accepted in the cycle after the previous one has reached the output
// register, which waits while the receiver holds off, so the block takes no
// new word until the previous one is through.
// Flags mask both memories to zero until they are first written, so no
// clearing pass follows reset.
module trimmed_mean_window_filter #(
  parameter int WINDOW_LEN  = 16,
  parameter int RANK_FIRST  = 6,
  parameter int RANK_END    = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] filtered
);
  import tmwf_pkg::*;

  localparam int AW        = $clog2(WINDOW_LEN);
  localparam int CNT_W     = $clog2(WINDOW_LEN + 2);
  localparam int RANK_STOP = (RANK_END > WINDOW_LEN) ? WINDOW_LEN : RANK_END;
  localparam int SPAN      = (RANK_STOP > RANK_FIRST) ? (RANK_STOP - RANK_FIRST) : 0;
  localparam int COUNT_W   = ($clog2(SPAN + 1) < 1) ? 1 : $clog2(SPAN + 1);
  localparam int SUM_W     = SAMPLE_BITS + COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OLD,
    S_SWEEP,
    S_START,
    S_DIV,
    S_HOLD
  } state_t;

  state_t state;

  logic [SAMPLE_BITS-1:0] s_reg;
  logic [SAMPLE_BITS-1:0] old;
  logic [SAMPLE_BITS-1:0] xa;
  logic [SAMPLE_BITS-1:0] xb;
  logic [SAMPLE_BITS-1:0] res;
  logic [AW-1:0]          wp;
  logic                   wrapped;
  logic                   sorted_init;
  logic [CNT_W-1:0]       cnt;
  logic                   removed;
  logic                   inserted;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_W-1:0]     nz;

  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [SAMPLE_BITS-1:0] srt_rdata;
  logic [SAMPLE_BITS-1:0] rdv;
  logic                   ring_we;
  logic                   srt_we;
  logic [AW-1:0]          widx;
  logic [SAMPLE_BITS-1:0] outv;
  logic [SAMPLE_BITS-1:0] a_k;
  logic                   hit;
  logic                   take_s;
  logic                   last;
  logic                   in_band;
  logic                   div_start;
  logic [SAMPLE_BITS-1:0] div_quot;
  div_status_t            div_stat;

  tmwf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (s_reg),
    .raddr (wp),
    .rdata (ring_rdata)
  );

  tmwf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_LEN)
  ) u_sorted (
    .clk   (clk),
    .we    (srt_we),
    .waddr (widx),
    .wdata (outv),
    .raddr (cnt[AW-1:0]),
    .rdata (srt_rdata)
  );

  tmwf_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_W),
    .QUOT_W     (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (nz),
    .quotient (div_quot),
    .status   (div_stat)
  );

  assign in_ready  = (state == S_IDLE);
  assign ring_we   = (state == S_OLD);
  assign srt_we    = (state == S_SWEEP) && (cnt >= CNT_W'(2));
  assign div_start = (state == S_START) && (nz != '0);
  assign rdv       = sorted_init ? srt_rdata : '0;
  assign widx      = AW'(cnt - CNT_W'(2));

  // Output entry k of the new sorted list is old entry k-1, k or k+1,
  // depending on whether the removed value and the new sample lie before it.
  // xa, xb and rdv hold old entries k-1, k and k+1.
  always_comb begin
    last    = (cnt == CNT_W'(WINDOW_LEN + 1));
    hit     = !removed && (xb == old);
    a_k     = (removed || hit) ? rdv : xb;
    take_s  = 1'b0;
    in_band = (int'(widx) >= RANK_FIRST) && (int'(widx) < RANK_STOP);
    if (inserted) begin
      outv = removed ? xb : xa;
    end else if ((a_k > s_reg) || last) begin
      outv   = s_reg;
      take_s = 1'b1;
    end else begin
      outv = a_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      wrapped     <= 1'b0;
      sorted_init <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
      removed     <= 1'b0;
      inserted    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            s_reg <= sample;
            state <= S_OLD;
          end
        end
        S_OLD: begin
          old      <= wrapped ? ring_rdata : '0;
          wp       <= (wp == AW'(WINDOW_LEN - 1)) ? '0 : wp + AW'(1);
          wrapped  <= wrapped || (wp == AW'(WINDOW_LEN - 1));
          removed  <= 1'b0;
          inserted <= 1'b0;
          sum      <= '0;
          nz       <= '0;
          state    <= S_SWEEP;
        end
        S_SWEEP: begin
          xa  <= xb;
          xb  <= rdv;
          cnt <= cnt + CNT_W'(1);
          if (cnt >= CNT_W'(2)) begin
            removed  <= removed || hit;
            inserted <= inserted || take_s;
            if (in_band && (outv != '0)) begin
              sum <= sum + SUM_W'(outv);
              nz  <= nz + COUNT_W'(1);
            end
          end
          if (last) begin
            sorted_init <= 1'b1;
            state       <= S_START;
          end
        end
        S_START: begin
          if (nz == '0) begin
            res   <= s_reg;
            state <= S_HOLD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res   <= (div_quot == '0) ? s_reg : div_quot;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            filtered  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The sorted memory always holds the window, so the pass must find the
  // overwritten value and place the new sample.
  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && last |=> removed && inserted)
    else $error("sorted pass ended without removing or inserting a word");

  a_div_tracked: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divider idle while a mean is pending");

  a_mean_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_stat.done |-> (div_quot != '0))
    else $error("mean of nonzero values came out zero");

endmodule

// ===== tb/sv/tb_trimmed_mean_window_filter.sv =====
module tb_trimmed_mean_window_filter;

  localparam int WINDOW_LEN  = 16;
  localparam int RANK_FIRST  = 6;
  localparam int RANK_END    = 10;
  localparam int SAMPLE_BITS = 12;
  localparam int RANDOM_WORDS = 1400;
  localparam int DIRECTED_ROWS = 25;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic    typed;
    sample_t want;
    sample_t value;
  } stim_row_t;

  typedef enum int {
    EP_NOISE,
    EP_SLOW,
    EP_ZEROS,
    EP_CONST,
    EP_SPIKES
  } episode_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t filtered;

  sample_t   window_ring [WINDOW_LEN];
  int        ring_pos;
  sample_t   expected_filtered [$];
  stim_row_t directed [DIRECTED_ROWS];
  int        errors = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  int        fallback_count = 0;
  int        mean_count = 0;
  bit        steady = 1'b0;
  bit        held_off = 1'b0;

  trimmed_mean_window_filter #(
    .WINDOW_LEN (WINDOW_LEN),
    .RANK_FIRST (RANK_FIRST),
    .RANK_END   (RANK_END),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered (filtered)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb_trimmed_mean_window_filter: done, errors");
    $finish;
  end

  // Stores the sample into the ring and returns the mean of the nonzero
  // values at the middle ranks, or the sample when there are none.
  function automatic sample_t next_filtered(input sample_t s);
    sample_t ranked [WINDOW_LEN];
    sample_t key;
    int      j;
    int      sum;
    int      count;
    window_ring[ring_pos] = s;
    ring_pos = (ring_pos + 1) % WINDOW_LEN;
    for (int i = 0; i < WINDOW_LEN; i++) ranked[i] = window_ring[i];
    for (int i = 1; i < WINDOW_LEN; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    sum = 0;
    count = 0;
    for (int r = RANK_FIRST; r < RANK_END && r < WINDOW_LEN; r++) begin
      if (ranked[r] != 0) begin
        sum += ranked[r];
        count++;
      end
    end
    if (count != 0 && sum / count != 0) begin
      mean_count++;
      return sample_t'(sum / count);
    end
    fallback_count++;
    return s;
  endfunction

  function automatic stim_row_t row(input sample_t value, input logic typed, input sample_t want);
    stim_row_t r;
    r.value = value;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic int idle_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_word(input sample_t v, input logic typed, input sample_t want);
    int      gap;
    sample_t predicted;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_filtered(v);
    expected_filtered.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_filtered.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %0d", $time, filtered);
        errors++;
      end else begin
        if (filtered !== expected_filtered[0]) begin
          $display("%0t: filtered mismatch, expected %0d, got %0d",
                   $time, expected_filtered[0], filtered);
          errors++;
        end
        void'(expected_filtered.pop_front());
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, and no
  // stalls at all during the steady stretch.
  initial begin
    int stall;
    repeat (11) @(posedge clk);
    forever begin
      if (!held_off && words_sent >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        if ($urandom_range(0, 24) == 0) stall = $urandom_range(30, 80);
        else stall = $urandom_range(0, 3);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    episode_t kind;
    int       run_len;
    int       random_sent;
    int       base;
    int       v;
    sample_t  level;

    for (int i = 0; i < WINDOW_LEN; i++) window_ring[i] = '0;
    ring_pos = 0;

    // While ten or more entries are zero the middle ranks are all zero, so
    // the first seven words after reset come straight back.
    directed[0] = row(12'd0, 1'b1, 12'd0);
    directed[1] = row(12'd4095, 1'b1, 12'd4095);
    directed[2] = row(12'd1, 1'b1, 12'd1);
    directed[3] = row(12'd2048, 1'b1, 12'd2048);
    directed[4] = row(12'hAAA, 1'b1, 12'hAAA);
    directed[5] = row(12'h555, 1'b1, 12'h555);
    directed[6] = row(12'h7FF, 1'b0, 12'd0);
    for (int i = 7; i < 22; i++) directed[i] = row(12'd4095, 1'b0, 12'd0);
    // Sixteen full-scale words in a row leave nothing else in the window.
    directed[22] = row(12'd4095, 1'b1, 12'd4095);
    directed[23] = row(12'd1, 1'b0, 12'd0);
    directed[24] = row(12'd0, 1'b0, 12'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(directed[i].value, directed[i].typed, directed[i].want);
    end

    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      kind = episode_t'($urandom_range(0, 4));
      run_len = $urandom_range(8, 40);
      base = $urandom_range(0, 4095);
      level = sample_t'($urandom_range(1, 4095));
      for (int k = 0; k < run_len && random_sent < RANDOM_WORDS; k++) begin
        steady = (random_sent >= 500 && random_sent < 650);
        case (kind)
          EP_NOISE: begin
            v = $urandom_range(0, 4095);
          end
          EP_SLOW: begin
            base = base + $urandom_range(0, 64) - 32;
            if (base < 0) base = 0;
            if (base > 4095) base = 4095;
            v = base;
          end
          EP_ZEROS: begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : 0;
          end
          EP_CONST: begin
            v = level;
          end
          default: begin
            // Steady level with outliers that the trimming should reject.
            if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1) ? 4095 : 0;
            else v = level;
          end
        endcase
        send_word(sample_t'(v), 1'b0, 12'd0);
        random_sent++;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words and checked %0d results: %0d trimmed means, %0d fallbacks.",
             words_sent, results_seen, mean_count, fallback_count);
    $display("Covered reset window, full-scale and zero runs, outliers and a long output hold.");
    if (errors == 0) begin
      $display("tb_trimmed_mean_window_filter: done, clean");
    end else begin
      $display("tb_trimmed_mean_window_filter: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tmwf_pkg.sv
design/tmwf_ram.sv
design/tmwf_divider.sv
design/trimmed_mean_window_filter.sv
tb/sv/tb_trimmed_mean_window_filter.sv
